// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared beat types, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int PRIO_BITS_DEF = 3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SERVE  = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] item_id;
        logic [2:0]  priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [2:0]  out_priority;
        logic [3:0]  position;
        logic [4:0]  occupancy;
        logic        empty_res;
    } res_item_t;

endpackage

// ===== rtl/core/spq_mem.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 19,
    parameter int IDX_W  = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue sequencer
// Walks the circular slot memory one entry per step for insert, serve and
// find, using one shared address unit, a priority compare and an id compare.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spq_pkg::in_item_t item,
    output logic              idle,
    input  logic              res_ready,
    output logic              done,
    output spq_pkg::res_item_t result
);
    import spq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int ENT_W = ID_BITS + PRIO_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [1:0]           kind_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [1:0]           res_status_reg, res_status_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic [PRIO_BITS-1:0] res_prio_reg, res_prio_next;
    logic [CNT_W-1:0]     res_pos_reg, res_pos_next;

    logic [CNT_W-1:0]     logical;
    logic [SUM_W-1:0]     addr_sum;
    logic [IDX_W-1:0]     phys;
    logic                 wr_en;
    logic                 rd_en;
    logic [ENT_W-1:0]     wr_data;
    logic [ENT_W-1:0]     rd_data;
    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;

    assign rd_id   = rd_data[ENT_W-1:PRIO_BITS];
    assign rd_prio = rd_data[PRIO_BITS-1:0];

    // Shared address unit: logical slot to physical memory index.
    always_comb
    begin
        if (state_reg == S_STEP && kind_reg == KIND_INSERT && scan_reg != '0)
        begin
            logical = scan_reg - CNT_W'(1);
        end
        else
        begin
            logical = scan_reg;
        end
        addr_sum = SUM_W'(head_reg) + SUM_W'(logical);
        if (addr_sum >= SUM_W'(DEPTH))
        begin
            phys = IDX_W'(addr_sum - SUM_W'(DEPTH));
        end
        else
        begin
            phys = IDX_W'(addr_sum);
        end
    end

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (phys),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (phys),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        res_pos_next    = res_pos_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_data         = {id_reg, prio_reg};
        done            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_status_next = ST_OK;
                res_id_next     = '0;
                res_prio_next   = '0;
                res_pos_next    = '0;
                scan_next       = '0;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            scan_next  = count_reg;
                            state_next = S_STEP;
                        end
                    end
                    KIND_SERVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                    KIND_FIND:
                    begin
                        state_next = S_STEP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_STEP:
            begin
                if (kind_reg == KIND_INSERT && scan_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else if (kind_reg == KIND_FIND && scan_reg == count_reg)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    wr_en = 1'b1;
                    if (rd_prio > prio_reg)
                    begin
                        wr_data    = rd_data;
                        scan_next  = scan_reg - CNT_W'(1);
                        state_next = S_STEP;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                else if (kind_reg == KIND_SERVE)
                begin
                    res_id_next   = rd_id;
                    res_prio_next = rd_prio;
                    count_next    = count_reg - CNT_W'(1);
                    if (head_reg == IDX_W'(DEPTH - 1))
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + IDX_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    if (rd_id == id_reg)
                    begin
                        res_id_next   = rd_id;
                        res_prio_next = rd_prio;
                        res_pos_next  = scan_reg;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + CNT_W'(1);
                        state_next = S_STEP;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            kind_reg <= item.kind;
            id_reg   <= ID_BITS'(item.item_id);
            prio_reg <= PRIO_BITS'(item.priority_req);
        end
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        res_pos_reg    <= res_pos_next;
    end

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        result.status       = res_status_reg;
        result.out_id       = 16'(res_id_reg);
        result.out_priority = 3'(res_prio_reg);
        result.position     = 4'(res_pos_reg);
        result.occupancy    = 5'(count_reg);
        result.empty_res    = (count_reg == '0);
    end

endmodule

// ===== rtl/core/stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue top level
// Throughput: one operation at a time; the next beat can be taken in the same
// cycle that the result is presented, and a stalled result holds the sequencer.
// Reset clears the queue to empty; slot contents stay undefined until written.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output spq_pkg::res_item_t out_data
);
    import spq_pkg::*;

    logic      ctrl_idle;
    logic      ctrl_done;
    logic      res_ready;
    logic      in_fire;
    res_item_t ctrl_result;
    logic      out_valid_reg, out_valid_next;
    res_item_t out_data_reg;

    assign in_stall  = !ctrl_idle;
    assign in_fire   = in_valid && !in_stall;
    assign res_ready = !out_valid_reg || !out_stall;

    spq_ctrl #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .item      (in_data),
        .idle      (ctrl_idle),
        .res_ready (res_ready),
        .done      (ctrl_done),
        .result    (ctrl_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_done)
        begin
            out_data_reg <= ctrl_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("sequencer ready right after taking a beat");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.empty_res)
        else $error("empty status reported on a nonempty queue");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |-> !out_data.empty_res)
        else $error("full status reported on an empty queue");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK
        |-> out_data.out_id == '0 && out_data.position == '0)
        else $error("failed operation carries entry data");

endmodule

// ===== test/spq_result_checker.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue result checker
// Watches both channels of the queue. Every accepted request beat is run
// through a local model of the sorted queue, and the reply that the model
// gives is held in order. Every accepted result beat is then compared field by
// field with the oldest held reply. The checker hands its error count and the
// number of replies still owed to the testbench top.
// ----------------------------------------------------------------------------
module spq_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  spq_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  spq_pkg::res_item_t out_data,
    output int                 fail_count,
    output int                 replies_owed
);
    import spq_pkg::*;

    logic [15:0] line_ids   [DEPTH_DEF];
    logic [2:0]  line_prios [DEPTH_DEF];
    int          line_count;
    res_item_t   reply_fifo [$];
    int          errs;

    function automatic res_item_t apply_queue_op(in_item_t beat);
        res_item_t reply;
        int        at;
        int        i;
        reply = '0;
        reply.status = ST_OK;
        unique case (beat.kind)
            KIND_INSERT:
            begin
                if (line_count >= DEPTH_DEF)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    // The new entry goes behind every entry of equal or lower level.
                    at = 0;
                    while (at < line_count && line_prios[at] <= beat.priority_req)
                    begin
                        at++;
                    end
                    for (i = line_count; i > at; i--)
                    begin
                        line_ids[i]   = line_ids[i - 1];
                        line_prios[i] = line_prios[i - 1];
                    end
                    line_ids[at]   = beat.item_id;
                    line_prios[at] = beat.priority_req;
                    line_count++;
                end
            end
            KIND_SERVE:
            begin
                if (line_count == 0)
                begin
                    reply.status = ST_EMPTY;
                end
                else
                begin
                    reply.out_id       = line_ids[0];
                    reply.out_priority = line_prios[0];
                    for (i = 1; i < line_count; i++)
                    begin
                        line_ids[i - 1]   = line_ids[i];
                        line_prios[i - 1] = line_prios[i];
                    end
                    line_count--;
                end
            end
            KIND_FIND:
            begin
                reply.status = ST_NOTFOUND;
                for (i = 0; i < line_count; i++)
                begin
                    if (reply.status == ST_NOTFOUND && line_ids[i] == beat.item_id)
                    begin
                        reply.status       = ST_OK;
                        reply.out_id       = line_ids[i];
                        reply.out_priority = line_prios[i];
                        reply.position     = 4'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        reply.occupancy = 5'(line_count);
        reply.empty_res = (line_count == 0);
        return reply;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            line_count = 0;
            reply_fifo.delete();
            errs = 0;
            fail_count   <= 0;
            replies_owed <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                reply_fifo.push_back(apply_queue_op(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (reply_fifo.size() == 0)
                begin
                    $error("result beat %h arrived with no request outstanding", out_data);
                    errs++;
                end
                else
                begin
                    want = reply_fifo.pop_front();
                    compare_field("status", 16'(want.status), 16'(out_data.status));
                    compare_field("out_id", want.out_id, out_data.out_id);
                    compare_field("out_priority", 16'(want.out_priority),
                                  16'(out_data.out_priority));
                    compare_field("position", 16'(want.position), 16'(out_data.position));
                    compare_field("occupancy", 16'(want.occupancy),
                                  16'(out_data.occupancy));
                    compare_field("empty_res", 16'(want.empty_res),
                                  16'(out_data.empty_res));
                end
            end
            fail_count   <= errs;
            replies_owed <= reply_fifo.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives insert, serve, find and unused operation beats into the queue: first
// a directed pass over the empty, full, ordering and lookup cases, then random
// traffic that swings between filling and draining, with ids drawn mostly from
// a small pool so that lookups hit and duplicates occur. Both sides idle and
// stall at random in several phases, and one long receiver hold-off backs the
// queue up. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         TIMEOUT_CYCLES = 400000;
    localparam int         HOLD_CYCLES    = 600;
    localparam int         RANDOM_BEATS   = 425;
    localparam int         TAIL_CYCLES    = 60;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    res_item_t out_data;
    int        fail_count;
    int        replies_owed;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_serial   = 0;
    int        cycle_count   = 0;

    stable_priority_queue_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    spq_result_checker reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : receiver
        int seen_hold;
        seen_hold = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_serial != seen_hold)
            begin
                seen_hold = hold_serial;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic offer_beat(input logic [1:0] kind, input logic [15:0] id,
                              input logic [2:0] prio);
        in_item_t beat;
        beat.kind         = kind;
        beat.item_id      = id;
        beat.priority_req = prio;
        in_data  <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int         ph;
        int         n;
        int         roll;
        bit         filling;
        logic [1:0] kind;
        logic [15:0] id;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_beat(KIND_SERVE, 16'h0000, 3'd0);
        offer_beat(KIND_FIND, 16'h0000, 3'd0);
        offer_beat(KIND_UNUSED, 16'hFFFF, 3'd7);
        offer_beat(KIND_INSERT, 16'hFFFF, 3'd7);
        offer_beat(KIND_INSERT, 16'h0000, 3'd0);
        offer_beat(KIND_INSERT, 16'h1234, 3'd7);
        offer_beat(KIND_INSERT, 16'hA5A5, 3'd3);
        offer_beat(KIND_FIND, 16'h1234, 3'd0);
        offer_beat(KIND_FIND, 16'hBEEF, 3'd5);
        offer_beat(KIND_UNUSED, 16'h0000, 3'd0);
        for (n = 0; n < 12; n++)
        begin
            offer_beat(KIND_INSERT, 16'h0100 + 16'(n), 3'(n));
        end
        offer_beat(KIND_INSERT, 16'h5A5A, 3'd0);
        offer_beat(KIND_FIND, 16'h1234, 3'd0);
        offer_beat(KIND_SERVE, 16'hFFFF, 3'd7);

        // Traffic leans toward inserts while filling and toward serves while
        // draining, so the queue keeps swinging between empty and full.
        filling = 1'b1;
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 38 : 0;
            stall_pct     = (ph == 2) ? 49 : (ph == 3) ? 38 : 0;
            for (n = 0; n < RANDOM_BEATS; n++)
            begin
                if (ph == 0 && n == 100)
                begin
                    hold_serial++;
                end
                if ($urandom_range(0, 49) == 0)
                begin
                    filling = !filling;
                end
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    kind = KIND_UNUSED;
                else if (roll < 20)
                    kind = KIND_FIND;
                else if ((roll < 75) == filling)
                    kind = KIND_INSERT;
                else
                    kind = KIND_SERVE;
                if ($urandom_range(0, 99) < 70)
                    id = 16'($urandom_range(0, 23));
                else
                    id = 16'($urandom);
                offer_beat(kind, id, 3'($urandom_range(0, 7)));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && replies_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
